>>> src/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

  localparam int ROM_DEPTH = 23;
  localparam int CHAN_W    = 8;
  localparam int IDX_W     = 5;
  localparam int SQ_W      = 2 * CHAN_W;
  localparam int DIST_W    = 18;
  localparam int COLOR_W   = 3 * CHAN_W;

  // packed as 0xRRGGBB
  localparam logic [COLOR_W-1:0] PALETTE [ROM_DEPTH] = '{
    24'hFFFFFF, 24'hC8C8C8, 24'h969696,
    24'h646464, 24'h323232, 24'h000000,
    24'hFF0000, 24'hC83232, 24'h964B4B,
    24'h00FF00, 24'h32C832, 24'h4B964B,
    24'h0000FF, 24'h3232C8, 24'h4B4B96,
    24'hFFFF00, 24'hFFA500, 24'h8B4513,
    24'h228B22, 24'h0080FF, 24'h800080,
    24'hFAF0BE, 24'hD2B48C
  };

  // one beat travelling down the chain: the pixel and the best entry so far
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } beat_t;

  function automatic logic [COLOR_W-1:0] palette_color(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    c = '0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (idx == IDX_W'(i)) begin
        c = PALETTE[i];
      end
    end
    return c;
  endfunction

endpackage

>>> src/npc_cell.sv
`timescale 1ns / 1ps

module npc_cell import npc_pkg::*; #(
  parameter int ENTRY = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  beat_t beat_in,
  output beat_t beat_out
);

  localparam logic [COLOR_W-1:0] COLOR = PALETTE[ENTRY];
  localparam logic [CHAN_W-1:0]  C_RED   = COLOR[3*CHAN_W-1:2*CHAN_W];
  localparam logic [CHAN_W-1:0]  C_GREEN = COLOR[2*CHAN_W-1:CHAN_W];
  localparam logic [CHAN_W-1:0]  C_BLUE  = COLOR[CHAN_W-1:0];

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[CHAN_W]) begin
      d = -d;
    end
    return d[CHAN_W-1:0];
  endfunction

  // stage one: squared channel differences
  beat_t           held;
  logic [SQ_W-1:0] sq_red, sq_green, sq_blue;
  logic [CHAN_W-1:0] d_red, d_green, d_blue;

  always_comb begin
    d_red   = abs_diff(beat_in.red, C_RED);
    d_green = abs_diff(beat_in.green, C_GREEN);
    d_blue  = abs_diff(beat_in.blue, C_BLUE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else begin
      held.valid <= beat_in.valid;
    end
    held.red      <= beat_in.red;
    held.green    <= beat_in.green;
    held.blue     <= beat_in.blue;
    held.idx      <= beat_in.idx;
    held.distance <= beat_in.distance;
    sq_red        <= SQ_W'(d_red) * SQ_W'(d_red);
    sq_green      <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue       <= SQ_W'(d_blue) * SQ_W'(d_blue);
  end

  // stage two: sum and keep the strictly smaller distance; entry zero always takes its own
  logic [DIST_W-1:0] cand_dist;
  logic              take;
  beat_t             beat_next;

  always_comb begin
    cand_dist = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
    take = (ENTRY == 0) || (cand_dist < held.distance);
    beat_next = held;
    if (take) begin
      beat_next.idx      = IDX_W'(ENTRY);
      beat_next.distance = cand_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= beat_next.valid;
    end
    beat_out.red      <= beat_next.red;
    beat_out.green    <= beat_next.green;
    beat_out.blue     <= beat_next.blue;
    beat_out.idx      <= beat_next.idx;
    beat_out.distance <= beat_next.distance;
  end

endmodule

>>> src/nearest_palette_color_unit.sv
`timescale 1ns / 1ps
// done is registered behind the N cells, N = PALETTE_ENTRIES clipped to 1..23
// throughput: one pixel per cycle, set by one two-stage cell per palette entry
// busy stays low, a start beat is taken in every cycle
// done is high for one cycle per result; the receiver cannot stall, results must be taken
// reset (rst, synchronous) clears the valid flags of the chain and done only

module nearest_palette_color_unit import npc_pkg::*; #(
  parameter int PALETTE_ENTRIES = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] pixel_red,
  input  logic [CHAN_W-1:0] pixel_green,
  input  logic [CHAN_W-1:0] pixel_blue,
  output logic              done,
  output logic [CHAN_W-1:0] match_red,
  output logic [CHAN_W-1:0] match_green,
  output logic [CHAN_W-1:0] match_blue,
  output logic [IDX_W-1:0]  match_index,
  output logic [DIST_W-1:0] match_distance
);

  // entries searched: clipped to the table, at least entry zero
  localparam int CELLS = (PALETTE_ENTRIES > ROM_DEPTH) ? ROM_DEPTH :
                         (PALETTE_ENTRIES < 1) ? 1 : PALETTE_ENTRIES;

  // every cycle can take a pixel, so the block never holds start off
  assign busy = 1'b0;

  // chain links: link 0 is the incoming pixel, link CELLS the finished beat
  beat_t link [CELLS+1];

  always_comb begin
    link[0].valid    = start & ~busy;
    link[0].red      = pixel_red;
    link[0].green    = pixel_green;
    link[0].blue     = pixel_blue;
    link[0].idx      = '0;
    link[0].distance = '0;
  end

  // one cell per palette entry, each compares against its own colour
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    npc_cell #(
      .ENTRY (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (link[g]),
      .beat_out (link[g+1])
    );
  end

  // result register: colour looked up from the winning index
  logic [COLOR_W-1:0] win_color;

  always_comb begin
    win_color = palette_color(link[CELLS].idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= link[CELLS].valid;
    end
    match_red      <= win_color[3*CHAN_W-1:2*CHAN_W];
    match_green    <= win_color[2*CHAN_W-1:CHAN_W];
    match_blue     <= win_color[CHAN_W-1:0];
    match_index    <= link[CELLS].idx;
    match_distance <= link[CELLS].distance;
  end

endmodule

>>> dv/nearest_palette_color_unit_tb.sv
`timescale 1ns / 1ps

module nearest_palette_color_unit_tb;
  import npc_pkg::*;

  // the unit is built with the full palette; the search count is clamped
  // to between one and the table size, as the hardware does
  localparam int PAL_N        = 23;
  localparam int SEARCHED     = (PAL_N > ROM_DEPTH) ? ROM_DEPTH : ((PAL_N < 1) ? 1 : PAL_N);
  localparam int PIPE_CYCLES  = 2 * SEARCHED + 1;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_BEATS = 700;

  // independent copy of the palette, packed as 0xRRGGBB
  localparam logic [COLOR_W-1:0] SWATCHES [ROM_DEPTH] = '{
    24'hFFFFFF, 24'hC8C8C8, 24'h969696,
    24'h646464, 24'h323232, 24'h000000,
    24'hFF0000, 24'hC83232, 24'h964B4B,
    24'h00FF00, 24'h32C832, 24'h4B964B,
    24'h0000FF, 24'h3232C8, 24'h4B4B96,
    24'hFFFF00, 24'hFFA500, 24'h8B4513,
    24'h228B22, 24'h0080FF, 24'h800080,
    24'hFAF0BE, 24'hD2B48C
  };

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } swatch_match_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] pixel_red;
  logic [CHAN_W-1:0] pixel_green;
  logic [CHAN_W-1:0] pixel_blue;
  logic              done;
  logic [CHAN_W-1:0] match_red;
  logic [CHAN_W-1:0] match_green;
  logic [CHAN_W-1:0] match_blue;
  logic [IDX_W-1:0]  match_index;
  logic [DIST_W-1:0] match_distance;

  swatch_match_t pending_matches [$];   // predicted results, oldest first
  int            mismatches = 0;
  int            stall_cycles = 0;
  bit            steady_stretch = 1'b0; // when set the sender never pauses

  nearest_palette_color_unit #(
    .PALETTE_ENTRIES(PAL_N)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .pixel_red      (pixel_red),
    .pixel_green    (pixel_green),
    .pixel_blue     (pixel_blue),
    .done           (done),
    .match_red      (match_red),
    .match_green    (match_green),
    .match_blue     (match_blue),
    .match_index    (match_index),
    .match_distance (match_distance)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // nearest swatch by squared distance; a later entry only wins when strictly
  // nearer, so equal distances keep the lowest index
  function automatic swatch_match_t nearest_swatch(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
    swatch_match_t m;
    int            dr;
    int            dg;
    int            db;
    int            sq_sum;
    int            best_dist;
    int            best_idx;
    best_dist = 0;
    best_idx  = 0;
    for (int i = 0; i < SEARCHED; i++) begin
      dr     = int'(r) - int'(SWATCHES[i][23:16]);
      dg     = int'(g) - int'(SWATCHES[i][15:8]);
      db     = int'(b) - int'(SWATCHES[i][7:0]);
      sq_sum = dr * dr + dg * dg + db * db;
      if (i == 0 || sq_sum < best_dist) begin
        best_dist = sq_sum;
        best_idx  = i;
      end
    end
    m.red      = SWATCHES[best_idx][23:16];
    m.green    = SWATCHES[best_idx][15:8];
    m.blue     = SWATCHES[best_idx][7:0];
    m.idx      = IDX_W'(best_idx);
    m.distance = DIST_W'(best_dist);
    return m;
  endfunction

  // move a channel by a random amount, saturating at the byte limits
  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c, input int spread);
    int v;
    v = int'(c) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  // random pause on the sending side, skipped during the steady stretch;
  // each cycle idles with a chance of about one in seven
  task automatic sender_gap();
    if (!steady_stretch && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 14) @(negedge clk);
    end
  endtask

  // offer one pixel from a falling edge and hold it until a rising edge takes it;
  // returns on the next falling edge with start still high
  task automatic drive_pixel(input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
    sender_gap();
    start       <= 1'b1;
    pixel_red   <= r;
    pixel_green <= g;
    pixel_blue  <= b;
    do @(posedge clk); while (busy);
    pending_matches.push_back(nearest_swatch(r, g, b));
    @(negedge clk);
  endtask

  // every entry hit exactly: each index appears, distance zero, and the
  // channel extremes come in through white, black and the primaries
  task automatic test_palette_hits();
    for (int i = 0; i < ROM_DEPTH; i++) begin
      drive_pixel(SWATCHES[i][23:16], SWATCHES[i][15:8], SWATCHES[i][7:0]);
    end
    // a corner with no swatch nearby
    drive_pixel(8'd0, 8'd255, 8'd255);
  endtask

  // grey points exactly midway between two grey entries: the first must win
  task automatic test_equal_distance_ties();
    drive_pixel(8'd125, 8'd125, 8'd125);
    drive_pixel(8'd25, 8'd25, 8'd25);
  endtask

  // mix of uniform pixels, pixels clustered round each swatch and points
  // between two swatches, where ties and near ties live
  task automatic test_random_pixels();
    int                 pick;
    int                 a;
    int                 c;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // a long run with the sender never pausing
      steady_stretch = (n >= 300 && n < 450);
      pick = $urandom_range(99);
      a    = $urandom_range(ROM_DEPTH - 1);
      c    = $urandom_range(ROM_DEPTH - 1);
      if (pick < 45) begin
        r = CHAN_W'($urandom);
        g = CHAN_W'($urandom);
        b = CHAN_W'($urandom);
      end else if (pick < 75) begin
        r = nudge(SWATCHES[a][23:16], 20);
        g = nudge(SWATCHES[a][15:8], 20);
        b = nudge(SWATCHES[a][7:0], 20);
      end else begin
        r = CHAN_W'((int'(SWATCHES[a][23:16]) + int'(SWATCHES[c][23:16])) / 2);
        g = CHAN_W'((int'(SWATCHES[a][15:8]) + int'(SWATCHES[c][15:8])) / 2);
        b = CHAN_W'((int'(SWATCHES[a][7:0]) + int'(SWATCHES[c][7:0])) / 2);
        if (pick >= 90) begin
          r = nudge(r, 2);
          g = nudge(g, 2);
          b = nudge(b, 2);
        end
      end
      drive_pixel(r, g, b);
    end
    steady_stretch = 1'b0;
  endtask

  // result beats cannot be held off, so every done cycle is taken and compared
  always @(posedge clk) begin
    swatch_match_t want;
    if (!rst && done) begin
      if (pending_matches.size() == 0) begin
        $error("result beat with no pixel outstanding: index %0d", match_index);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        if (match_red !== want.red) begin
          $error("match_red: expected %0d, got %0d", want.red, match_red);
          mismatches++;
        end
        if (match_green !== want.green) begin
          $error("match_green: expected %0d, got %0d", want.green, match_green);
          mismatches++;
        end
        if (match_blue !== want.blue) begin
          $error("match_blue: expected %0d, got %0d", want.blue, match_blue);
          mismatches++;
        end
        if (match_index !== want.idx) begin
          $error("match_index: expected %0d, got %0d", want.idx, match_index);
          mismatches++;
        end
        if (match_distance !== want.distance) begin
          $error("match_distance: expected %0d, got %0d", want.distance, match_distance);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too many cycles in a row with neither a pixel nor a result moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    pixel_red   = '0;
    pixel_green = '0;
    pixel_blue  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_palette_hits();
    test_equal_distance_ties();
    test_random_pixels();
    start <= 1'b0;

    // drain the pipeline, then give it the full latency to show any stray beat
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> nearest_palette_color_unit.f
src/npc_pkg.sv
src/npc_cell.sv
src/nearest_palette_color_unit.sv
dv/nearest_palette_color_unit_tb.sv
